### rtl/lbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LED blink controller.
// No dependencies; used by lbc_led_lane and led_blink_controller_unit.
package lbc_pkg;

    localparam int LED_COUNT_DEF  = 2;
    localparam int SCAN_TICKS_DEF = 5;
    localparam int LED_MAX        = 4;
    localparam int INDEX_W        = 2;
    localparam int TIME_W         = 16;
    localparam int COUNT_W        = 17;
    localparam int PRESCALE_W     = 3;
    localparam int LIT_W          = 2;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ON    = 2'd1,
        OP_OFF   = 2'd2,
        OP_BLINK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2
    } mode_t;

    typedef struct packed {
        logic scan;
        logic write;
        op_t  op;
    } lane_ctrl_t;

endpackage

### rtl/lbc_led_lane.sv
`timescale 1ns / 1ps
// State and scan logic for one LED: mode, blink phase, phase counter, drive.
// Depends on lbc_pkg.
module lbc_led_lane #(
    parameter int SCAN_TICKS = lbc_pkg::SCAN_TICKS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lbc_pkg::lane_ctrl_t       ctrl,
    input  logic [lbc_pkg::TIME_W-1:0] on_time,
    input  logic [lbc_pkg::TIME_W-1:0] off_time,
    output logic                      drive_next
);

    lbc_pkg::mode_t                    mode_reg, mode_next;
    logic                              phase_on_reg, phase_on_next;
    logic [lbc_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [lbc_pkg::TIME_W-1:0]        lit_dur_reg, lit_dur_next;
    logic [lbc_pkg::TIME_W-1:0]        dark_dur_reg, dark_dur_next;
    logic                              drive_reg;
    logic [lbc_pkg::COUNT_W:0]         count_sum;
    logic [lbc_pkg::COUNT_W-1:0]       count_sat;
    logic                              scan_lit;

    always_comb
    begin
        count_sum = {1'b0, count_reg} + (lbc_pkg::COUNT_W + 1)'(SCAN_TICKS);
        count_sat = count_sum[lbc_pkg::COUNT_W] ? '1 : count_sum[lbc_pkg::COUNT_W-1:0];

        mode_next     = mode_reg;
        phase_on_next = phase_on_reg;
        count_next    = count_reg;
        lit_dur_next  = lit_dur_reg;
        dark_dur_next = dark_dur_reg;
        scan_lit      = 1'b0;

        if (ctrl.scan)
        begin
            unique case (mode_reg)
                lbc_pkg::MODE_ON:
                begin
                    scan_lit = 1'b1;
                end
                lbc_pkg::MODE_BLINK:
                begin
                    count_next = count_sat;
                    if (phase_on_reg)
                    begin
                        scan_lit = 1'b1;
                        if (count_sat >= lbc_pkg::COUNT_W'(lit_dur_reg))
                        begin
                            phase_on_next = 1'b0;
                            count_next    = '0;
                        end
                    end
                    else if (count_sat >= lbc_pkg::COUNT_W'(dark_dur_reg))
                    begin
                        phase_on_next = 1'b1;
                        count_next    = '0;
                    end
                end
                default:
                begin
                    scan_lit = 1'b0;
                end
            endcase
        end
        else if (ctrl.write)
        begin
            unique case (ctrl.op)
                lbc_pkg::OP_ON:
                begin
                    mode_next = lbc_pkg::MODE_ON;
                end
                lbc_pkg::OP_OFF:
                begin
                    mode_next = lbc_pkg::MODE_OFF;
                end
                lbc_pkg::OP_BLINK:
                begin
                    mode_next     = lbc_pkg::MODE_BLINK;
                    phase_on_next = 1'b1;
                    count_next    = '0;
                    lit_dur_next  = on_time;
                    dark_dur_next = off_time;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        drive_next = ctrl.scan ? scan_lit : drive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= lbc_pkg::MODE_OFF;
            phase_on_reg <= 1'b0;
            count_reg    <= '0;
            lit_dur_reg  <= '0;
            dark_dur_reg <= '0;
            drive_reg    <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            phase_on_reg <= phase_on_next;
            count_reg    <= count_next;
            lit_dur_reg  <= lit_dur_next;
            dark_dur_reg <= dark_dur_next;
            drive_reg    <= drive_next;
        end
    end

endmodule

### rtl/led_blink_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the LED blink controller: tick prescaler, command decode,
// one lane per LED and the result register. Depends on lbc_pkg, lbc_led_lane.
//
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | led_index[1:0] on_time[17:2] off_time[33:18] | opcode[1:0]
//  m_axis   | out | led_lit[1:0]                           | status[0] drive_updated[1]
//
// One item per cycle while ready: each item updates the LED lanes and loads the
// result register at the edge it is accepted, so its result is valid the next
// cycle. The result register frees when taken; s_axis_tready stays high while it
// is empty or being taken in the same cycle. Reset leaves all LEDs off and dark.
module led_blink_controller_unit #(
    parameter int LED_COUNT  = lbc_pkg::LED_COUNT_DEF,
    parameter int SCAN_TICKS = lbc_pkg::SCAN_TICKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // led_index[1:0], on_time[17:2], off_time[33:18], zero fill
    input  logic [lbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // led_lit[1:0], zero fill
    output logic [lbc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[0], drive_updated[1]
    output logic [1:0]                     m_axis_tuser
);

    logic                              accept;
    lbc_pkg::op_t                      op;
    logic [lbc_pkg::INDEX_W-1:0]       led_index;
    logic [lbc_pkg::TIME_W-1:0]        on_time;
    logic [lbc_pkg::TIME_W-1:0]        off_time;
    logic                              is_tick;
    logic                              index_ok;
    logic                              scan;
    logic [lbc_pkg::PRESCALE_W-1:0]    prescale_reg, prescale_next;
    logic [lbc_pkg::PRESCALE_W-1:0]    prescale_inc;
    logic [LED_COUNT-1:0]              lit_vec;
    logic [lbc_pkg::LED_MAX-1:0]       lit_wide;
    logic                              out_valid_reg;
    logic                              status_reg, status_next;
    logic                              updated_reg, updated_next;
    logic [lbc_pkg::LIT_W-1:0]         lit_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op        = lbc_pkg::op_t'(s_axis_tuser);
    assign led_index = s_axis_tdata[lbc_pkg::INDEX_W-1:0];
    assign on_time   = s_axis_tdata[lbc_pkg::INDEX_W +: lbc_pkg::TIME_W];
    assign off_time  = s_axis_tdata[lbc_pkg::INDEX_W + lbc_pkg::TIME_W +: lbc_pkg::TIME_W];

    assign is_tick  = (op == lbc_pkg::OP_TICK);
    assign index_ok = (32'(led_index) < LED_COUNT);

    always_comb
    begin
        prescale_inc  = prescale_reg + 1'b1;
        scan          = 1'b0;
        prescale_next = prescale_reg;
        if (accept && is_tick)
        begin
            if (32'(prescale_inc) >= SCAN_TICKS)
            begin
                prescale_next = '0;
                scan          = 1'b1;
            end
            else
            begin
                prescale_next = prescale_inc;
            end
        end
    end

    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_lane
        lbc_pkg::lane_ctrl_t lane_ctrl;

        assign lane_ctrl.scan  = scan;
        assign lane_ctrl.write = accept && !is_tick && index_ok
                                 && (led_index == lbc_pkg::INDEX_W'(i));
        assign lane_ctrl.op    = op;

        lbc_led_lane #(
            .SCAN_TICKS (SCAN_TICKS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .on_time    (on_time),
            .off_time   (off_time),
            .drive_next (lit_vec[i])
        );
    end

    assign lit_wide     = lbc_pkg::LED_MAX'(lit_vec);
    assign status_next  = !is_tick && !index_ok;
    assign updated_next = scan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            updated_reg <= updated_next;
            lit_reg     <= lit_wide[lbc_pkg::LIT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = lbc_pkg::OUT_DATA_W'(lit_reg);
    assign m_axis_tuser  = {updated_reg, status_reg};

endmodule
